FILE: rtl/core/lmap_pkg.sv
// shared constants, types and fixed-point helpers for the lens distortion map
`timescale 1ns / 1ps
package lmap_pkg;

	// field widths and fixed-point formats
	localparam int COORD_BITS   = 12;
	localparam int FRAC_BITS    = 20;
	localparam int OUT_BITS     = 28;
	localparam int INNER_BITS   = 32;
	localparam int COEF_BITS    = 24;
	localparam int COEF_FRAC    = 20;
	localparam int INV_BITS     = 24;
	localparam int CTR_BITS     = 16;
	localparam int SUBPIX_BITS  = 4;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_IDX_BITS = 3;

	// normalize rescale: product carries 28 fraction bits
	localparam int NORM_SHIFT = 28 - FRAC_BITS;
	localparam int NORM_RSH   = (NORM_SHIFT > 0) ? NORM_SHIFT : 0;
	localparam int NORM_LSH   = (NORM_SHIFT > 0) ? 0 : -NORM_SHIFT;

	// datapath widths
	localparam int PIX16_BITS = COORD_BITS + SUBPIX_BITS;
	localparam int D_W   = ((PIX16_BITS > CTR_BITS) ? PIX16_BITS : CTR_BITS) + 1;
	localparam int PN_W  = D_W + INV_BITS + 1;
	localparam int SQ_W  = 2 * OUT_BITS;
	localparam int PW_W  = 2 * INNER_BITS;
	localparam int KR_W  = COEF_BITS + INNER_BITS;
	localparam int RK_W  = KR_W - COEF_FRAC + 1;
	localparam int ACC_W = RK_W + 1;
	localparam int TS_W  = INNER_BITS + 2;
	localparam int RXP_W = INNER_BITS + OUT_BITS;
	localparam int TXP_W = COEF_BITS + INNER_BITS;
	localparam int TTP_W = COEF_BITS + TS_W;
	localparam int RX_W  = RXP_W - FRAC_BITS + 1;
	localparam int TX_W  = TXP_W + 1 - COEF_FRAC + 1;
	localparam int TT_W  = TTP_W - COEF_FRAC + 1;
	localparam int TERM_A = (RX_W > TX_W) ? RX_W : TX_W;
	localparam int TERM_W = (TERM_A > TT_W) ? TERM_A : TT_W;

	localparam logic signed [63:0] ONE_FIX = 64'sd1 <<< FRAC_BITS;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_PRINCIPAL = 3'd0,
		CFG_INV_FX    = 3'd1,
		CFG_INV_FY    = 3'd2,
		CFG_K1        = 3'd3,
		CFG_K2        = 3'd4,
		CFG_K3        = 3'd5,
		CFG_P1        = 3'd6,
		CFG_P2        = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [CTR_BITS-1:0]         ctr_x;
		logic [CTR_BITS-1:0]         ctr_y;
		logic [INV_BITS-1:0]         inv_fx;
		logic [INV_BITS-1:0]         inv_fy;
		logic signed [COEF_BITS-1:0] k1;
		logic signed [COEF_BITS-1:0] k2;
		logic signed [COEF_BITS-1:0] k3;
		logic signed [COEF_BITS-1:0] p1;
		logic signed [COEF_BITS-1:0] p2;
	} cfg_regs_t;

	// normalized coordinates leaving the front end
	typedef struct packed {
		logic                       vld;
		logic                       ovf;
		logic signed [OUT_BITS-1:0] x;
		logic signed [OUT_BITS-1:0] y;
	} nrm_bus_t;

	// radial factor and aligned operands for the final terms
	typedef struct packed {
		logic                         vld;
		logic                         ovf;
		logic signed [OUT_BITS-1:0]   x;
		logic signed [OUT_BITS-1:0]   y;
		logic signed [INNER_BITS-1:0] xy;
		logic signed [TS_W-1:0]       tsx;
		logic signed [TS_W-1:0]       tsy;
		logic signed [INNER_BITS-1:0] radial;
	} rad_bus_t;

	// round to nearest, ties up, then arithmetic shift right
	function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
			input int unsigned s);
		logic signed [63:0] half;
		half = (s == 0) ? 64'sd0 : (64'sd1 <<< (s - 1));
		return (v + half) >>> s;
	endfunction

	function automatic logic signed [63:0] sat_clip(input logic signed [63:0] v,
			input int unsigned bits);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (v > hi) begin
			return hi;
		end else if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	function automatic logic sat_hit(input logic signed [63:0] v, input int unsigned bits);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		return (v > hi) || (v < lo);
	endfunction

endpackage

FILE: rtl/core/lmap_cfg.sv
// configuration register file for the lens distortion map
`timescale 1ns / 1ps
module lmap_cfg import lmap_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [CFG_IDX_BITS-1:0]  wr_index,
	input  logic [CFG_DATA_BITS-1:0] wr_data,
	output cfg_regs_t                regs
);

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.ctr_x  <= '0;
			regs_q.ctr_y  <= '0;
			regs_q.inv_fx <= {INV_BITS{1'b1}};
			regs_q.inv_fy <= {INV_BITS{1'b1}};
			regs_q.k1     <= '0;
			regs_q.k2     <= '0;
			regs_q.k3     <= '0;
			regs_q.p1     <= '0;
			regs_q.p2     <= '0;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_PRINCIPAL: begin
					regs_q.ctr_x <= wr_data[CTR_BITS-1:0];
					regs_q.ctr_y <= wr_data[2*CTR_BITS-1:CTR_BITS];
				end
				CFG_INV_FX: regs_q.inv_fx <= wr_data[INV_BITS-1:0];
				CFG_INV_FY: regs_q.inv_fy <= wr_data[INV_BITS-1:0];
				CFG_K1:     regs_q.k1     <= $signed(wr_data[COEF_BITS-1:0]);
				CFG_K2:     regs_q.k2     <= $signed(wr_data[COEF_BITS-1:0]);
				CFG_K3:     regs_q.k3     <= $signed(wr_data[COEF_BITS-1:0]);
				CFG_P1:     regs_q.p1     <= $signed(wr_data[COEF_BITS-1:0]);
				CFG_P2:     regs_q.p2     <= $signed(wr_data[COEF_BITS-1:0]);
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

FILE: rtl/core/lmap_norm.sv
// front end: principal point offset, focal scaling, rounding to normalized coords
`timescale 1ns / 1ps
module lmap_norm import lmap_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic [COORD_BITS-1:0] pix_x,
	input  logic [COORD_BITS-1:0] pix_y,
	input  cfg_regs_t             cfg_regs,
	output nrm_bus_t              nrm
);

	logic signed [D_W-1:0]  dx, dy;
	logic signed [PN_W-1:0] px_s1, py_s1;
	logic                   vld_s1, vld_s2;
	logic signed [63:0]     nx_full, ny_full, nx_sat, ny_sat;
	logic signed [OUT_BITS-1:0] x_s2, y_s2;
	logic                   ovf_s2;

	// offset in 1/16 pixel units
	assign dx = $signed(D_W'({pix_x, {SUBPIX_BITS{1'b0}}})) - $signed(D_W'(cfg_regs.ctr_x));
	assign dy = $signed(D_W'({pix_y, {SUBPIX_BITS{1'b0}}})) - $signed(D_W'(cfg_regs.ctr_y));

	assign nx_full = rnd_shr(64'(px_s1), NORM_RSH) <<< NORM_LSH;
	assign ny_full = rnd_shr(64'(py_s1), NORM_RSH) <<< NORM_LSH;
	assign nx_sat  = sat_clip(nx_full, OUT_BITS);
	assign ny_sat  = sat_clip(ny_full, OUT_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1  <= dx * $signed({1'b0, cfg_regs.inv_fx});
			py_s1  <= dy * $signed({1'b0, cfg_regs.inv_fy});
			x_s2   <= nx_sat[OUT_BITS-1:0];
			y_s2   <= ny_sat[OUT_BITS-1:0];
			ovf_s2 <= sat_hit(nx_full, OUT_BITS) | sat_hit(ny_full, OUT_BITS);
		end
	end

	assign nrm.vld = vld_s2;
	assign nrm.ovf = ovf_s2;
	assign nrm.x   = x_s2;
	assign nrm.y   = y_s2;

endmodule

FILE: rtl/core/lmap_poly.sv
// middle section: squares, r2/r4/r6 and the radial factor
`timescale 1ns / 1ps
module lmap_poly import lmap_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  nrm_bus_t  nrm,
	input  cfg_regs_t cfg_regs,
	output rad_bus_t  rad
);

	logic [11:3] vld;

	logic signed [OUT_BITS-1:0]   x_s3, y_s3, x_s4, y_s4, x_s5, y_s5, x_s6, y_s6;
	logic signed [OUT_BITS-1:0]   x_s7, y_s7, x_s8, y_s8, x_s9, y_s9, x_s10, y_s10;
	logic signed [OUT_BITS-1:0]   x_s11, y_s11;
	logic                         ovf_s3, ovf_s4, ovf_s5, ovf_s6, ovf_s7, ovf_s8;
	logic                         ovf_s9, ovf_s10, ovf_s11;
	logic signed [SQ_W-1:0]       xxp_s3, yyp_s3, xyp_s3;
	logic signed [INNER_BITS-1:0] xx_s4, yy_s4, xy_s4, xx_s5, yy_s5, xy_s5, r2_s5;
	logic signed [INNER_BITS-1:0] xy_s6, r2_s6, xy_s7, r2_s7, r4_s7, xy_s8, xy_s9;
	logic signed [INNER_BITS-1:0] r6_s9, xy_s10, xy_s11, radial_s11;
	logic signed [TS_W-1:0]       tsx_s6, tsy_s6, tsx_s7, tsy_s7, tsx_s8, tsy_s8;
	logic signed [TS_W-1:0]       tsx_s9, tsy_s9, tsx_s10, tsy_s10, tsx_s11, tsy_s11;
	logic signed [PW_W-1:0]       r2sq_s6, r4r2_s8;
	logic signed [KR_W-1:0]       k1r2_s6, k2r4_s8, k3r6_s10;
	logic signed [RK_W-1:0]       t1_s7, t1_s8;
	logic signed [ACC_W-1:0]      acc_s9, acc_s10;

	logic signed [63:0] xx_r, yy_r, xy_r, xx_c, yy_c, xy_c;
	logic signed [63:0] r2_sum, r2_c, r4_r, r4_c, t1_r, r6_r, r6_c, acc_sum;
	logic signed [63:0] rad_sum, rad_c;

	// s4: rescale squares
	assign xx_r = rnd_shr(64'(xxp_s3), FRAC_BITS);
	assign yy_r = rnd_shr(64'(yyp_s3), FRAC_BITS);
	assign xy_r = rnd_shr(64'(xyp_s3), FRAC_BITS);
	assign xx_c = sat_clip(xx_r, INNER_BITS);
	assign yy_c = sat_clip(yy_r, INNER_BITS);
	assign xy_c = sat_clip(xy_r, INNER_BITS);
	// s5: r2
	assign r2_sum = 64'(xx_s4) + 64'(yy_s4);
	assign r2_c   = sat_clip(r2_sum, INNER_BITS);
	// s7: r4 and first coefficient term
	assign r4_r = rnd_shr(64'(r2sq_s6), FRAC_BITS);
	assign r4_c = sat_clip(r4_r, INNER_BITS);
	assign t1_r = rnd_shr(64'(k1r2_s6), COEF_FRAC);
	// s9: r6 and partial radial sum
	assign r6_r    = rnd_shr(64'(r4r2_s8), FRAC_BITS);
	assign r6_c    = sat_clip(r6_r, INNER_BITS);
	assign acc_sum = 64'(t1_s8) + rnd_shr(64'(k2r4_s8), COEF_FRAC);
	// s11: radial factor
	assign rad_sum = ONE_FIX + 64'(acc_s10) + rnd_shr(64'(k3r6_s10), COEF_FRAC);
	assign rad_c   = sat_clip(rad_sum, INNER_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (en) begin
			vld <= {vld[10:3], nrm.vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s3
			xxp_s3 <= nrm.x * nrm.x;
			yyp_s3 <= nrm.y * nrm.y;
			xyp_s3 <= nrm.x * nrm.y;
			x_s3   <= nrm.x;
			y_s3   <= nrm.y;
			ovf_s3 <= nrm.ovf;
			// s4
			xx_s4  <= xx_c[INNER_BITS-1:0];
			yy_s4  <= yy_c[INNER_BITS-1:0];
			xy_s4  <= xy_c[INNER_BITS-1:0];
			ovf_s4 <= ovf_s3 | sat_hit(xx_r, INNER_BITS) | sat_hit(yy_r, INNER_BITS)
				| sat_hit(xy_r, INNER_BITS);
			x_s4   <= x_s3;
			y_s4   <= y_s3;
			// s5
			r2_s5  <= r2_c[INNER_BITS-1:0];
			xx_s5  <= xx_s4;
			yy_s5  <= yy_s4;
			xy_s5  <= xy_s4;
			ovf_s5 <= ovf_s4 | sat_hit(r2_sum, INNER_BITS);
			x_s5   <= x_s4;
			y_s5   <= y_s4;
			// s6
			r2sq_s6 <= r2_s5 * r2_s5;
			k1r2_s6 <= $signed(cfg_regs.k1) * r2_s5;
			tsx_s6  <= TS_W'(r2_s5) + (TS_W'(xx_s5) <<< 1);
			tsy_s6  <= TS_W'(r2_s5) + (TS_W'(yy_s5) <<< 1);
			r2_s6   <= r2_s5;
			xy_s6   <= xy_s5;
			ovf_s6  <= ovf_s5;
			x_s6    <= x_s5;
			y_s6    <= y_s5;
			// s7
			r4_s7  <= r4_c[INNER_BITS-1:0];
			t1_s7  <= t1_r[RK_W-1:0];
			r2_s7  <= r2_s6;
			xy_s7  <= xy_s6;
			tsx_s7 <= tsx_s6;
			tsy_s7 <= tsy_s6;
			ovf_s7 <= ovf_s6 | sat_hit(r4_r, INNER_BITS);
			x_s7   <= x_s6;
			y_s7   <= y_s6;
			// s8
			r4r2_s8 <= r4_s7 * r2_s7;
			k2r4_s8 <= $signed(cfg_regs.k2) * r4_s7;
			t1_s8   <= t1_s7;
			xy_s8   <= xy_s7;
			tsx_s8  <= tsx_s7;
			tsy_s8  <= tsy_s7;
			ovf_s8  <= ovf_s7;
			x_s8    <= x_s7;
			y_s8    <= y_s7;
			// s9
			r6_s9  <= r6_c[INNER_BITS-1:0];
			acc_s9 <= acc_sum[ACC_W-1:0];
			xy_s9  <= xy_s8;
			tsx_s9 <= tsx_s8;
			tsy_s9 <= tsy_s8;
			ovf_s9 <= ovf_s8 | sat_hit(r6_r, INNER_BITS);
			x_s9   <= x_s8;
			y_s9   <= y_s8;
			// s10
			k3r6_s10 <= $signed(cfg_regs.k3) * r6_s9;
			acc_s10  <= acc_s9;
			xy_s10   <= xy_s9;
			tsx_s10  <= tsx_s9;
			tsy_s10  <= tsy_s9;
			ovf_s10  <= ovf_s9;
			x_s10    <= x_s9;
			y_s10    <= y_s9;
			// s11
			radial_s11 <= rad_c[INNER_BITS-1:0];
			xy_s11     <= xy_s10;
			tsx_s11    <= tsx_s10;
			tsy_s11    <= tsy_s10;
			ovf_s11    <= ovf_s10 | sat_hit(rad_sum, INNER_BITS);
			x_s11      <= x_s10;
			y_s11      <= y_s10;
		end
	end

	assign rad.vld    = vld[11];
	assign rad.ovf    = ovf_s11;
	assign rad.x      = x_s11;
	assign rad.y      = y_s11;
	assign rad.xy     = xy_s11;
	assign rad.tsx    = tsx_s11;
	assign rad.tsy    = tsy_s11;
	assign rad.radial = radial_s11;

endmodule

FILE: rtl/core/lmap_dist.sv
// back end: radial and tangential terms, final saturation, output register
`timescale 1ns / 1ps
module lmap_dist import lmap_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  rad_bus_t                    rad,
	input  cfg_regs_t                   cfg_regs,
	output logic                        vld_out,
	output logic signed [OUT_BITS-1:0]  nx_out,
	output logic signed [OUT_BITS-1:0]  ny_out,
	output logic signed [OUT_BITS-1:0]  dx_out,
	output logic signed [OUT_BITS-1:0]  dy_out,
	output logic                        ovf_out
);

	logic                       vld_s12, vld_s13, vld_s14;
	logic                       ovf_s12, ovf_s13, ovf_s14;
	logic signed [OUT_BITS-1:0] x_s12, y_s12, x_s13, y_s13, x_s14, y_s14;
	logic signed [OUT_BITS-1:0] dx_s14, dy_s14;
	logic signed [RXP_W-1:0]    rxp_s12, ryp_s12;
	logic signed [TXP_W-1:0]    p1xyp_s12, p2xyp_s12;
	logic signed [TTP_W-1:0]    p2tsxp_s12, p1tsyp_s12;
	logic signed [TERM_W-1:0]   xa_s13, xb_s13, xc_s13, ya_s13, yb_s13, yc_s13;

	logic signed [63:0] xa, xb, xc, ya, yb, yc, dx_sum, dy_sum, dx_c, dy_c;

	// s13: rescale each term
	assign xa = rnd_shr(64'(rxp_s12), FRAC_BITS);
	assign xb = rnd_shr(64'(p1xyp_s12) <<< 1, COEF_FRAC);
	assign xc = rnd_shr(64'(p2tsxp_s12), COEF_FRAC);
	assign ya = rnd_shr(64'(ryp_s12), FRAC_BITS);
	assign yb = rnd_shr(64'(p1tsyp_s12), COEF_FRAC);
	assign yc = rnd_shr(64'(p2xyp_s12) <<< 1, COEF_FRAC);
	// s14: sum and clamp
	assign dx_sum = 64'(xa_s13) + 64'(xb_s13) + 64'(xc_s13);
	assign dy_sum = 64'(ya_s13) + 64'(yb_s13) + 64'(yc_s13);
	assign dx_c   = sat_clip(dx_sum, OUT_BITS);
	assign dy_c   = sat_clip(dy_sum, OUT_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
		end else if (en) begin
			vld_s12 <= rad.vld;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s12
			rxp_s12    <= rad.radial * rad.x;
			ryp_s12    <= rad.radial * rad.y;
			p1xyp_s12  <= $signed(cfg_regs.p1) * rad.xy;
			p2xyp_s12  <= $signed(cfg_regs.p2) * rad.xy;
			p2tsxp_s12 <= $signed(cfg_regs.p2) * rad.tsx;
			p1tsyp_s12 <= $signed(cfg_regs.p1) * rad.tsy;
			ovf_s12    <= rad.ovf;
			x_s12      <= rad.x;
			y_s12      <= rad.y;
			// s13
			xa_s13  <= xa[TERM_W-1:0];
			xb_s13  <= xb[TERM_W-1:0];
			xc_s13  <= xc[TERM_W-1:0];
			ya_s13  <= ya[TERM_W-1:0];
			yb_s13  <= yb[TERM_W-1:0];
			yc_s13  <= yc[TERM_W-1:0];
			ovf_s13 <= ovf_s12;
			x_s13   <= x_s12;
			y_s13   <= y_s12;
			// s14
			dx_s14  <= dx_c[OUT_BITS-1:0];
			dy_s14  <= dy_c[OUT_BITS-1:0];
			ovf_s14 <= ovf_s13 | sat_hit(dx_sum, OUT_BITS) | sat_hit(dy_sum, OUT_BITS);
			x_s14   <= x_s13;
			y_s14   <= y_s13;
		end
	end

	assign vld_out = vld_s14;
	assign nx_out  = x_s14;
	assign ny_out  = y_s14;
	assign dx_out  = dx_s14;
	assign dy_out  = dy_s14;
	assign ovf_out = ovf_s14;

endmodule

FILE: rtl/core/lens_distortion_map_core.sv
// top level of the brown-conrady lens distortion map
//
//  channel   direction  handshake              word
//  in        sink       in_valid / in_ready    pixel_x, pixel_y
//  out       source     out_valid / out_ready  norm_x, norm_y, dist_x, dist_y, overflow
//  cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  one word in and one word out per clock when the output is taken every cycle
//  fourteen register stages, set by the chain of dependent
//  multiplies (offset*focal, x*x, r2*r2, r4*r2, k3*r6, radial*x), each followed by
//  a rounding stage
//  reset clears the stage valid bits and loads the register defaults; no clearing pass
//  a stall (out_valid high, out_ready low) freezes every stage together, so
//  in_ready drops in the same cycle and nothing is lost or repeated
//  cfg_ready is always high; registers are read at several stages, so writes
//  belong in a gap with no word in flight
`timescale 1ns / 1ps
module lens_distortion_map_core import lmap_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	// pixel input
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [COORD_BITS-1:0]       pixel_x,
	input  logic [COORD_BITS-1:0]       pixel_y,
	// result output
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [OUT_BITS-1:0]  norm_x,
	output logic signed [OUT_BITS-1:0]  norm_y,
	output logic signed [OUT_BITS-1:0]  dist_x,
	output logic signed [OUT_BITS-1:0]  dist_y,
	output logic                        overflow,
	// register writes
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [CFG_DATA_BITS-1:0]    cfg_data
);

	logic      pipe_en;
	cfg_regs_t cfg_regs;
	nrm_bus_t  nrm;
	rad_bus_t  rad;

	// whole pipe advances unless the output word is held back
	assign pipe_en   = !out_valid || out_ready;
	assign in_ready  = pipe_en;
	assign cfg_ready = 1'b1;

	lmap_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.regs     (cfg_regs)
	);

	// stages 1-2: offset, focal scaling, round and clamp
	lmap_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_vld   (in_valid),
		.pix_x    (pixel_x),
		.pix_y    (pixel_y),
		.cfg_regs (cfg_regs),
		.nrm      (nrm)
	);

	// stages 3-11: squares, powers of r and the radial factor
	lmap_poly u_poly (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.nrm      (nrm),
		.cfg_regs (cfg_regs),
		.rad      (rad)
	);

	// stages 12-14: radial and tangential terms, stage 14 is the output register
	lmap_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.rad      (rad),
		.cfg_regs (cfg_regs),
		.vld_out  (out_valid),
		.nx_out   (norm_x),
		.ny_out   (norm_y),
		.dx_out   (dist_x),
		.dy_out   (dist_y),
		.ovf_out  (overflow)
	);

endmodule

FILE: rtl/core/lmap_chk.sv
// port-level checker for the lens distortion map, bound to the top level
`timescale 1ns / 1ps
module lmap_chk import lmap_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [OUT_BITS-1:0] norm_x,
	input logic signed [OUT_BITS-1:0] dist_x,
	input logic                       overflow
);

	// a held result word does not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(norm_x) && $stable(dist_x)
			&& $stable(overflow))
		else $error("output word changed during stall");

	// input side stalls exactly when the output word is held
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow the output stall");

	// once reset has been seen at an edge, nothing is presented at the next one
	a_rst_idle: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("out_valid high right after reset");

endmodule

bind lens_distortion_map_core lmap_chk u_lmap_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.norm_x    (norm_x),
	.dist_x    (dist_x),
	.overflow  (overflow)
);

FILE: tb/sv/lens_distortion_map_core_tb.sv
// self-checking testbench for the brown-conrady lens distortion map core
`timescale 1ns / 1ps
module lens_distortion_map_core_tb;
	import lmap_pkg::*;

	// no handshake on any channel for this long means a hang
	localparam int WATCHDOG_LIMIT = 1000;
	// pipeline depth is 14 stages; the tail wait leaves margin for stray words
	localparam int TAIL_CYCLES    = 30;
	// one long receiver stall so the pipeline backs up into in_ready
	localparam int HOLD_AT        = 200;
	localparam int HOLD_CYCLES    = 120;

	// flavors of camera programmed between phases
	typedef enum int {
		CAM_TYPICAL,
		CAM_STRONG,
		CAM_WILD,
		CAM_EXTREME_HI,
		CAM_EXTREME_LO
	} cam_kind_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
	} pixel_word_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] norm_x;
		logic signed [OUT_BITS-1:0] norm_y;
		logic signed [OUT_BITS-1:0] dist_x;
		logic signed [OUT_BITS-1:0] dist_y;
		logic                       overflow;
	} lens_map_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// block inputs start at known values
	logic                     in_valid  = 1'b0;
	logic [COORD_BITS-1:0]    pixel_x   = '0;
	logic [COORD_BITS-1:0]    pixel_y   = '0;
	logic                     out_ready = 1'b0;
	logic                     cfg_valid = 1'b0;
	cfg_idx_t                 cfg_index = CFG_PRINCIPAL;
	logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

	// block outputs
	logic                       in_ready;
	logic                       out_valid;
	logic signed [OUT_BITS-1:0] norm_x;
	logic signed [OUT_BITS-1:0] norm_y;
	logic signed [OUT_BITS-1:0] dist_x;
	logic signed [OUT_BITS-1:0] dist_y;
	logic                       overflow;
	logic                       cfg_ready;

	// camera registers as the block should hold them
	cfg_regs_t camera;

	pixel_word_t pixel_queue[$];
	lens_map_t   expected_maps[$];
	pixel_word_t next_pixel;
	lens_map_t   want;

	int  words_queued   = 0;
	int  words_accepted = 0;
	int  results_seen   = 0;
	int  fail_count     = 0;
	int  quiet_cycles   = 0;
	logic in_fire       = 1'b0;

	// idle percentages per side, set phase by phase
	int in_idle_pct  = 0;
	int out_idle_pct = 0;
	int in_gap       = 0;
	int out_gap      = 0;
	int hold_left    = 0;
	logic hold_done  = 1'b0;

	lens_distortion_map_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.norm_x    (norm_x),
		.norm_y    (norm_y),
		.dist_x    (dist_x),
		.dist_y    (dist_y),
		.overflow  (overflow),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// rescale by a right shift, rounding half up
	function automatic longint round_shift(input longint v, input int s);
		if (s == 0) begin
			return v;
		end
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	// clamp into a signed range of the given width
	function automatic longint clamp(input longint v, input int bits);
		longint top;
		top = (64'sd1 <<< (bits - 1)) - 64'sd1;
		if (v > top) begin
			return top;
		end
		if (v < -top - 64'sd1) begin
			return -top - 64'sd1;
		end
		return v;
	endfunction

	// normalize one axis: offset from the centre in 1/16 pixel times the reciprocal focal
	function automatic longint normalize(input logic [COORD_BITS-1:0] pix,
			input logic [CTR_BITS-1:0] centre, input logic [INV_BITS-1:0] inv);
		longint offset;
		offset = (longint'(pix) <<< SUBPIX_BITS) - longint'(centre);
		return round_shift(offset * longint'(inv), NORM_RSH) <<< NORM_LSH;
	endfunction

	// full distortion of one pixel under the current camera
	function automatic lens_map_t distort_pixel(input logic [COORD_BITS-1:0] px,
			input logic [COORD_BITS-1:0] py);
		lens_map_t res;
		logic    clipped;
		longint  raw, x, y, xx, yy, xy, r2, r4, r6, radial, dx, dy;
		longint  k1, k2, k3, p1, p2;
		clipped = 1'b0;
		k1 = longint'(camera.k1);
		k2 = longint'(camera.k2);
		k3 = longint'(camera.k3);
		p1 = longint'(camera.p1);
		p2 = longint'(camera.p2);

		raw = normalize(px, camera.ctr_x, camera.inv_fx);
		x = clamp(raw, OUT_BITS);
		clipped |= (x != raw);
		raw = normalize(py, camera.ctr_y, camera.inv_fy);
		y = clamp(raw, OUT_BITS);
		clipped |= (y != raw);

		// squares and cross term
		raw = round_shift(x * x, FRAC_BITS);
		xx = clamp(raw, INNER_BITS);
		clipped |= (xx != raw);
		raw = round_shift(y * y, FRAC_BITS);
		yy = clamp(raw, INNER_BITS);
		clipped |= (yy != raw);
		raw = round_shift(x * y, FRAC_BITS);
		xy = clamp(raw, INNER_BITS);
		clipped |= (xy != raw);

		// powers of the radius
		raw = xx + yy;
		r2 = clamp(raw, INNER_BITS);
		clipped |= (r2 != raw);
		raw = round_shift(r2 * r2, FRAC_BITS);
		r4 = clamp(raw, INNER_BITS);
		clipped |= (r4 != raw);
		raw = round_shift(r4 * r2, FRAC_BITS);
		r6 = clamp(raw, INNER_BITS);
		clipped |= (r6 != raw);

		raw = (64'sd1 <<< FRAC_BITS) + round_shift(k1 * r2, COEF_FRAC)
			+ round_shift(k2 * r4, COEF_FRAC) + round_shift(k3 * r6, COEF_FRAC);
		radial = clamp(raw, INNER_BITS);
		clipped |= (radial != raw);

		// radial scaling plus the two tangential terms
		raw = round_shift(radial * x, FRAC_BITS) + round_shift(2 * p1 * xy, COEF_FRAC)
			+ round_shift(p2 * (r2 + 2 * xx), COEF_FRAC);
		dx = clamp(raw, OUT_BITS);
		clipped |= (dx != raw);
		raw = round_shift(radial * y, FRAC_BITS) + round_shift(p1 * (r2 + 2 * yy), COEF_FRAC)
			+ round_shift(2 * p2 * xy, COEF_FRAC);
		dy = clamp(raw, OUT_BITS);
		clipped |= (dy != raw);

		res.norm_x   = x[OUT_BITS-1:0];
		res.norm_y   = y[OUT_BITS-1:0];
		res.dist_x   = dx[OUT_BITS-1:0];
		res.dist_y   = dy[OUT_BITS-1:0];
		res.overflow = clipped;
		return res;
	endfunction

	function automatic void check_field(input string name, input longint want_v,
			input longint got_v);
		if (want_v != got_v) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
			fail_count++;
		end
	endfunction

	// register write; cfg_valid stays high for a following write and is
	// lowered by the caller after the last one
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		case (idx)
			CFG_PRINCIPAL: begin
				camera.ctr_x = data[CTR_BITS-1:0];
				camera.ctr_y = data[2*CTR_BITS-1:CTR_BITS];
			end
			CFG_INV_FX: camera.inv_fx = data[INV_BITS-1:0];
			CFG_INV_FY: camera.inv_fy = data[INV_BITS-1:0];
			CFG_K1:     camera.k1 = data[COEF_BITS-1:0];
			CFG_K2:     camera.k2 = data[COEF_BITS-1:0];
			CFG_K3:     camera.k3 = data[COEF_BITS-1:0];
			CFG_P1:     camera.p1 = data[COEF_BITS-1:0];
			CFG_P2:     camera.p2 = data[COEF_BITS-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// coefficient with random junk above bit 23, which the block must ignore
	function automatic logic [CFG_DATA_BITS-1:0] coef_word(input int v);
		logic [CFG_DATA_BITS-1:0] w;
		w = $urandom;
		w[COEF_BITS-1:0] = v[COEF_BITS-1:0];
		return w;
	endfunction

	function automatic int signed_pick(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	task automatic program_camera(input cam_kind_t kind);
		logic [CFG_DATA_BITS-1:0] pp, ifx, ify, c1, c2, c3, t1, t2;
		int cx, cy;
		cx = 2048 * 16 + signed_pick(6000);
		cy = 2048 * 16 + signed_pick(6000);
		pp  = {cy[15:0], cx[15:0]};
		ifx = coef_word((1 << 24) / int'($urandom_range(400, 6000)));
		ify = coef_word((1 << 24) / int'($urandom_range(400, 6000)));
		c1  = coef_word(signed_pick(524288));
		c2  = coef_word(signed_pick(262144));
		c3  = coef_word(signed_pick(104858));
		t1  = coef_word(signed_pick(10486));
		t2  = coef_word(signed_pick(10486));
		case (kind)
			CAM_STRONG: begin
				// typical geometry, coefficients pinned to either end
				c1 = coef_word($urandom_range(1) ? 32'h7FFFFF : 32'h800000);
				c2 = coef_word($urandom_range(1) ? 32'h7FFFFF : 32'h800000);
				c3 = coef_word($urandom_range(1) ? 32'h7FFFFF : 32'h800000);
				t1 = coef_word($urandom_range(1) ? 32'h7FFFFF : 32'h800000);
				t2 = coef_word($urandom_range(1) ? 32'h7FFFFF : 32'h800000);
			end
			CAM_WILD: begin
				pp  = $urandom;
				ifx = $urandom;
				ify = $urandom;
				c1  = $urandom;
				c2  = $urandom;
				c3  = $urandom;
				t1  = $urandom;
				t2  = $urandom;
			end
			CAM_EXTREME_HI: begin
				pp  = '1;
				ifx = 32'h00FF_FFFF;
				ify = 32'h00FF_FFFF;
				c1  = 32'h007F_FFFF;
				c2  = 32'h007F_FFFF;
				c3  = 32'h007F_FFFF;
				t1  = 32'h007F_FFFF;
				t2  = 32'h007F_FFFF;
			end
			CAM_EXTREME_LO: begin
				pp  = '0;
				ifx = 32'd1;
				ify = 32'd1;
				c1  = 32'h0080_0000;
				c2  = 32'h0080_0000;
				c3  = 32'h0080_0000;
				t1  = 32'h0080_0000;
				t2  = 32'h0080_0000;
			end
			default: begin
			end
		endcase
		write_reg(CFG_PRINCIPAL, pp);
		write_reg(CFG_INV_FX, ifx);
		write_reg(CFG_INV_FY, ify);
		write_reg(CFG_K1, c1);
		write_reg(CFG_K2, c2);
		write_reg(CFG_K3, c3);
		write_reg(CFG_P1, t1);
		write_reg(CFG_P2, t2);
		end_writes();
	endtask

	task automatic queue_pixel(input int x, input int y);
		pixel_word_t w;
		w.x = x[COORD_BITS-1:0];
		w.y = y[COORD_BITS-1:0];
		pixel_queue.push_back(w);
		words_queued++;
	endtask

	// mostly uniform over the sensor, a quarter clustered around the optical centre
	task automatic queue_random(input int n);
		int x, y;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(3) == 0) begin
				x = int'(camera.ctr_x >> SUBPIX_BITS) + signed_pick(16);
				y = int'(camera.ctr_y >> SUBPIX_BITS) + signed_pick(16);
				x = (x < 0) ? 0 : ((x > 4095) ? 4095 : x);
				y = (y < 0) ? 0 : ((y > 4095) ? 4095 : y);
			end else begin
				x = $urandom_range(0, 4095);
				y = $urandom_range(0, 4095);
			end
			queue_pixel(x, y);
		end
	endtask

	// block is idle once every queued word went in and every result came out
	task automatic settle();
		@(negedge clk);
		while (words_accepted != words_queued || expected_maps.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic run_phase(input cam_kind_t kind, input int n, input int in_pct,
			input int out_pct);
		program_camera(kind);
		in_idle_pct  = in_pct;
		out_idle_pct = out_pct;
		queue_random(n);
		settle();
	endtask

	// stimulus sequence
	initial begin
		camera.ctr_x  = '0;
		camera.ctr_y  = '0;
		camera.inv_fx = '1;
		camera.inv_fy = '1;
		camera.k1 = '0;
		camera.k2 = '0;
		camera.k3 = '0;
		camera.p1 = '0;
		camera.p2 = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset defaults: huge reciprocal focal, every corner but the origin saturates
		in_idle_pct  = 20;
		out_idle_pct = 20;
		queue_pixel(0, 0);
		queue_pixel(4095, 4095);
		queue_pixel(4095, 0);
		queue_pixel(0, 4095);
		queue_pixel(1, 2);
		settle();

		// a plausible lens; the pixel on the optical centre maps to zero
		write_reg(CFG_PRINCIPAL, {16'(1536 * 16), 16'(2048 * 16)});
		write_reg(CFG_INV_FX, 32'd8389);
		write_reg(CFG_INV_FY, 32'd8389);
		write_reg(CFG_K1, coef_word(-314573));
		write_reg(CFG_K2, coef_word(104858));
		write_reg(CFG_K3, coef_word(-10486));
		write_reg(CFG_P1, coef_word(1049));
		write_reg(CFG_P2, coef_word(-2097));
		end_writes();
		queue_pixel(2048, 1536);
		queue_pixel(2049, 1536);
		queue_pixel(2048, 1537);
		queue_pixel(0, 0);
		queue_pixel(4095, 4095);
		queue_pixel(0, 4095);
		settle();

		// zero reciprocal focal lengths give zero normalized coordinates
		write_reg(CFG_INV_FX, 32'hFF00_0000);
		write_reg(CFG_INV_FY, 32'd0);
		end_writes();
		queue_pixel(4095, 0);
		queue_pixel(0, 4095);
		queue_pixel(2048, 1536);
		settle();

		// random phases, the long receiver hold lands in the second one
		run_phase(CAM_TYPICAL, 150, 15, 25);
		run_phase(CAM_WILD, 80, 30, 0);
		run_phase(CAM_TYPICAL, 150, 0, 40);
		run_phase(CAM_EXTREME_HI, 50, 25, 25);
		run_phase(CAM_STRONG, 80, 10, 10);
		run_phase(CAM_TYPICAL, 150, 40, 15);
		run_phase(CAM_EXTREME_LO, 50, 0, 0);
		run_phase(CAM_WILD, 80, 20, 30);
		run_phase(CAM_TYPICAL, 150, 25, 0);
		// last part runs at full rate, no idling on either side
		run_phase(CAM_TYPICAL, 120, 0, 0);

		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("** lens_distortion_map_core: PASSED **");
		end else begin
			$display("** lens_distortion_map_core: FAILED **");
		end
		$finish;
	end

	// input driver: holds a word until taken, idles in random bursts
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (in_gap != 0) begin
				in_valid <= 1'b0;
				in_gap   <= in_gap - 1;
			end else if (pixel_queue.size() == 0) begin
				in_valid <= 1'b0;
			end else if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
				in_valid <= 1'b0;
				in_gap   <= $urandom_range(0, 14);
			end else begin
				next_pixel = pixel_queue.pop_front();
				in_valid <= 1'b1;
				pixel_x  <= next_pixel.x;
				pixel_y  <= next_pixel.y;
			end
		end
	end

	// output ready: random stall bursts plus one long hold so the block backs up
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (!hold_done && results_seen >= HOLD_AT) begin
				out_ready <= 1'b0;
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES - 1;
			end else if (out_gap != 0) begin
				out_ready <= 1'b0;
				out_gap   <= out_gap - 1;
			end else if (out_idle_pct != 0 && $urandom_range(99) < out_idle_pct) begin
				out_ready <= 1'b0;
				out_gap   <= $urandom_range(0, 14);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// monitor: retire the oldest prediction on each result word, then predict
	// for any pixel word taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			in_fire <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_maps.size() == 0) begin
					$display("%0t: result word with nothing pending, expected none actual %0d %0d",
						$time, norm_x, norm_y);
					fail_count++;
				end else begin
					want = expected_maps.pop_front();
					check_field("norm_x", want.norm_x, norm_x);
					check_field("norm_y", want.norm_y, norm_y);
					check_field("dist_x", want.dist_x, dist_x);
					check_field("dist_y", want.dist_y, dist_y);
					check_field("overflow", want.overflow, overflow);
				end
			end
			if (in_valid && in_ready) begin
				expected_maps.push_back(distort_pixel(pixel_x, pixel_y));
				words_accepted++;
			end
		end
	end

	// watchdog: too long with no handshake on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
				$display("** lens_distortion_map_core: FAILED **");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

endmodule

FILE: sim.f
rtl/core/lmap_pkg.sv
rtl/core/lmap_cfg.sv
rtl/core/lmap_norm.sv
rtl/core/lmap_poly.sv
rtl/core/lmap_dist.sv
rtl/core/lens_distortion_map_core.sv
rtl/core/lmap_chk.sv
tb/sv/lens_distortion_map_core_tb.sv
